// ----- sv/til_pkg.sv -----
// Shared types for the trie word store: transfer payloads, queued operations
// and the back-end state encoding. No dependencies.
package til_pkg;

	// Input transfer: one letter of a word and its tags
	typedef struct packed {
		logic       func;       // 0 insert, 1 lookup
		logic [4:0] letter;     // 0 = a .. 25 = z
		logic       has_letter;
		logic       last;
	} til_req_t;

	// Result transfer, one per word
	typedef struct packed {
		logic found;
		logic pool_full;
	} til_rsp_t;

	// Classified operation handed from front to back
	typedef struct packed {
		logic       is_lookup;
		logic       walk;       // item carries a usable letter
		logic [4:0] letter;
		logic       last;
	} til_op_t;

	localparam int unsigned FUNC_INSERT = 0;
	localparam int unsigned FUNC_LOOKUP = 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_LINK,
		ST_EVAL,
		ST_MARK,
		ST_CLOSE
	} til_state_t;

endpackage

// ----- sv/til_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module til_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/til_front.sv -----
// Front end: takes input transfers, classifies each item and queues the
// ones that matter for the back end. Depends on til_pkg.
module til_front #(
	parameter int ALPHABET = 26
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  til_pkg::til_req_t req,
	input  logic              clearing,
	output logic              op_valid,
	output til_pkg::til_op_t  op,
	input  logic              op_pop
);

	// two-entry queue
	til_pkg::til_op_t q_mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	til_pkg::til_op_t cls;
	logic             accept;
	logic             push;

	// a letter past the alphabet counts as no letter
	always_comb begin
		cls.is_lookup = (req.func == 1'(til_pkg::FUNC_LOOKUP));
		cls.walk      = req.has_letter && (32'(req.letter) < ALPHABET);
		cls.letter    = req.letter;
		cls.last      = req.last;
	end

	assign req_ready = (cnt_q != 2'd2) && !clearing;
	assign accept    = req_valid && req_ready;
	// no letter and not last: nothing to do
	assign push      = accept && (cls.walk || cls.last);

	assign op_valid = (cnt_q != 2'd0);
	assign op       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (op_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, op_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/til_back.sv -----
// Back end: walks and extends the trie held in the child-link and word-end
// RAMs, one queued operation at a time. Depends on til_pkg and til_ram.
module til_back #(
	parameter int NODES    = 1024,
	parameter int ALPHABET = 26
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  til_pkg::til_op_t  op,
	output logic              op_pop,
	output logic              clearing,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output til_pkg::til_rsp_t rsp
);

	localparam int NODE_W = $clog2(NODES);
	localparam int FREE_W = $clog2(NODES + 1);
	localparam int LINKS  = NODES * ALPHABET;
	localparam int ADDR_W = $clog2(LINKS);

	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(LINKS - 1);
	localparam logic [ADDR_W-1:0] ALPH_C    = ADDR_W'(ALPHABET);
	localparam logic [FREE_W-1:0] NODES_C   = FREE_W'(NODES);

	til_pkg::til_state_t state_q, state_d;

	til_pkg::til_op_t  op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] clr_q;
	logic [NODE_W-1:0] cur_q;
	logic [FREE_W-1:0] free_q;
	logic              missed_q;
	logic              failed_q;
	logic              rsp_valid_q;
	til_pkg::til_rsp_t rsp_q;

	// memory ports
	logic              link_we, link_re;
	logic [ADDR_W-1:0] link_waddr;
	logic [NODE_W-1:0] link_wdata, link_rdata;
	logic              mark_we, mark_re;
	logic [NODE_W-1:0] mark_waddr;
	logic              mark_wdata, mark_rdata;

	logic              clean;
	logic              pool_empty;
	logic              no_child;
	logic              do_alloc;
	logic              close_fire;
	logic              out_free;

	assign clean      = !missed_q && !failed_q;
	assign pool_empty = (free_q >= NODES_C);
	assign no_child   = (link_rdata == '0);
	assign out_free   = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			til_pkg::ST_CLEAR: begin
				if (clr_q == ADDR_LAST) state_d = til_pkg::ST_IDLE;
			end
			til_pkg::ST_IDLE: begin
				if (op_valid) begin
					if (op.walk && clean)  state_d = til_pkg::ST_ADDR;
					else if (op.last)      state_d = til_pkg::ST_MARK;
				end
			end
			til_pkg::ST_ADDR:  state_d = til_pkg::ST_LINK;
			til_pkg::ST_LINK:  state_d = til_pkg::ST_EVAL;
			til_pkg::ST_EVAL:  state_d = op_q.last ? til_pkg::ST_MARK : til_pkg::ST_IDLE;
			til_pkg::ST_MARK:  state_d = til_pkg::ST_CLOSE;
			til_pkg::ST_CLOSE: begin
				if (out_free) state_d = til_pkg::ST_IDLE;
			end
			default: state_d = til_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		op_pop     = 1'b0;
		clearing   = 1'b0;
		link_we    = 1'b0;
		link_waddr = addr_q;
		link_wdata = free_q[NODE_W-1:0];
		link_re    = 1'b0;
		mark_we    = 1'b0;
		mark_waddr = cur_q;
		mark_wdata = 1'b0;
		mark_re    = 1'b0;
		do_alloc   = 1'b0;
		close_fire = 1'b0;
		case (state_q)
			til_pkg::ST_CLEAR: begin
				clearing   = 1'b1;
				link_we    = 1'b1;
				link_waddr = clr_q;
				link_wdata = '0;
				mark_we    = 1'b1;
				mark_waddr = clr_q[NODE_W-1:0];
			end
			til_pkg::ST_IDLE: op_pop = op_valid;
			til_pkg::ST_LINK: link_re = 1'b1;
			til_pkg::ST_EVAL: begin
				// new node: link it and clear its word-end mark
				do_alloc   = no_child && !op_q.is_lookup && !pool_empty;
				link_we    = do_alloc;
				mark_we    = do_alloc;
				mark_waddr = free_q[NODE_W-1:0];
			end
			til_pkg::ST_MARK: mark_re = 1'b1;
			til_pkg::ST_CLOSE: begin
				close_fire = out_free;
				mark_we    = out_free && !op_q.is_lookup && clean;
				mark_wdata = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op;
		end
		if (state_q == til_pkg::ST_ADDR) begin
			addr_q <= ADDR_W'(cur_q) * ALPH_C + ADDR_W'(op_q.letter);
		end
		if (close_fire) begin
			rsp_q.found     <= op_q.is_lookup && clean && mark_rdata;
			rsp_q.pool_full <= !op_q.is_lookup && failed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= til_pkg::ST_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			free_q      <= FREE_W'(1);
			missed_q    <= 1'b0;
			failed_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == til_pkg::ST_EVAL) begin
				if (!no_child) begin
					cur_q <= link_rdata;
				end else if (op_q.is_lookup) begin
					missed_q <= 1'b1;
				end else if (pool_empty) begin
					failed_q <= 1'b1;
				end else begin
					cur_q  <= free_q[NODE_W-1:0];
					free_q <= free_q + FREE_W'(1);
				end
			end
			if (close_fire) begin
				cur_q    <= '0;
				missed_q <= 1'b0;
				failed_q <= 1'b0;
			end
			if (close_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	til_ram #(
		.WIDTH (NODE_W),
		.DEPTH (LINKS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (addr_q),
		.rdata (link_rdata)
	);

	til_ram #(
		.WIDTH (1),
		.DEPTH (NODES)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (mark_re),
		.raddr (cur_q),
		.rdata (mark_rdata)
	);

endmodule

// ----- sv/trie_insert_lookup.sv -----
// Trie word store: front queue feeding the link-walking back end (til_pkg, til_front,
// til_back, til_ram). A letter item passes pop, address, link read and evaluate; a
// closing item adds a mark read and the result register; a bare word end takes pop,
// mark read and result register. No new item is popped until the last is through, and
// the result step waits while an earlier result is untaken. Reset: asynchronous; then
// a clearing pass over every link address zeroes both RAMs while req_ready stays low.
module trie_insert_lookup #(
	parameter int NODES    = 1024,
	parameter int ALPHABET = 26
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  til_pkg::til_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output til_pkg::til_rsp_t rsp
);

	// front/back hand-off
	logic             op_valid;
	logic             op_pop;
	logic             clearing;
	til_pkg::til_op_t op;

	// Front: one transfer per cycle, while the two-deep queue has room and no clearing
	// pass runs. Items with no usable letter that do not end a word are dropped here.
	til_front #(
		.ALPHABET (ALPHABET)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.clearing  (clearing),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop)
	);

	// Back: address compute, link read, evaluate/allocate, then on the last item a
	// word-end read and the registered result; a letterless last item skips to the read.
	til_back #(
		.NODES    (NODES),
		.ALPHABET (ALPHABET)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
